@@ src/sbst_pkg.sv @@
`default_nettype none

package sbst_pkg;

  // Coordinate width of every point and box field.
  localparam int unsigned CoordWidth = 16;
  // Differences of two coordinates need one more bit.
  localparam int unsigned DiffWidth = CoordWidth + 1;
  // Width of a cross product of a numerator and a denominator.
  localparam int unsigned ProdWidth = 2 * DiffWidth;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned AxisX = 0;
  localparam int unsigned AxisY = 1;
  localparam int unsigned AxisZ = 2;

  localparam int unsigned DimWidth = 2;
  localparam logic [DimWidth-1:0] DimTwo = 2'd2;
  localparam logic [DimWidth-1:0] DimCountReset = 2'd3;

  // Ordered pairs of distinct axes: the entry bound of one axis is checked
  // against the exit bound of the other.
  localparam int unsigned NumPairs = NumAxes * (NumAxes - 1);
  localparam int unsigned PairEntry [NumPairs] = '{0, 0, 1, 1, 2, 2};
  localparam int unsigned PairExit  [NumPairs] = '{1, 2, 0, 2, 0, 1};

  // What one lane found for its axis. The entry and exit parameters share the
  // denominator den, which is always positive when the lane is active.
  typedef struct packed {
    logic                        active;
    logic                        ok;
    logic signed [DiffWidth-1:0] nmin;
    logic signed [DiffWidth-1:0] nmax;
    logic [CoordWidth-1:0]       den;
  } lane_t;

endpackage

`default_nettype wire

@@ src/sbst_if.sv @@
`default_nettype none

interface sbst_cfg_if import sbst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DimWidth-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sbst_req_if import sbst_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] start_x;
  logic signed [CoordWidth-1:0] start_y;
  logic signed [CoordWidth-1:0] start_z;
  logic signed [CoordWidth-1:0] end_x;
  logic signed [CoordWidth-1:0] end_y;
  logic signed [CoordWidth-1:0] end_z;
  logic signed [CoordWidth-1:0] box_lo_x;
  logic signed [CoordWidth-1:0] box_lo_y;
  logic signed [CoordWidth-1:0] box_lo_z;
  logic signed [CoordWidth-1:0] box_hi_x;
  logic signed [CoordWidth-1:0] box_hi_y;
  logic signed [CoordWidth-1:0] box_hi_z;

  modport source (
    output valid, input ready,
    output start_x, output start_y, output start_z,
    output end_x, output end_y, output end_z,
    output box_lo_x, output box_lo_y, output box_lo_z,
    output box_hi_x, output box_hi_y, output box_hi_z
  );
  modport sink (
    input valid, output ready,
    input start_x, input start_y, input start_z,
    input end_x, input end_y, input end_z,
    input box_lo_x, input box_lo_y, input box_lo_z,
    input box_hi_x, input box_hi_y, input box_hi_z
  );
endinterface

interface sbst_rsp_if import sbst_pkg::*; ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink (input valid, input hit, output ready);
endinterface

`default_nettype wire

@@ src/sbst_lane.sv @@
`default_nettype none

module sbst_lane import sbst_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic                         axis_on,
  input  wire logic signed [CoordWidth-1:0] s,
  input  wire logic signed [CoordWidth-1:0] e,
  input  wire logic signed [CoordWidth-1:0] lo,
  input  wire logic signed [CoordWidth-1:0] hi,
  output lane_t                             res
);

  logic signed [DiffWidth-1:0] d;
  logic signed [DiffWidth-1:0] hi_s;
  logic signed [DiffWidth-1:0] s_lo;
  logic signed [DiffWidth-1:0] mag;
  logic signed [DiffWidth-1:0] den_s;
  logic                        d_pos;
  logic                        d_zero;
  logic                        miss;
  lane_t                       res_next;

  always_comb begin
    d    = $signed({e[CoordWidth-1], e}) - $signed({s[CoordWidth-1], s});
    hi_s = $signed({hi[CoordWidth-1], hi}) - $signed({s[CoordWidth-1], s});
    s_lo = $signed({s[CoordWidth-1], s}) - $signed({lo[CoordWidth-1], lo});
    d_zero = (d == '0);
    d_pos  = !d[DiffWidth-1] && !d_zero;
    mag    = d[DiffWidth-1] ? -d : d;
    // A segment parallel to this axis misses when its start lies outside.
    miss   = hi_s[DiffWidth-1] || s_lo[DiffWidth-1];

    res_next.den  = mag[CoordWidth-1:0];
    res_next.nmin = d_pos ? -s_lo : -hi_s;
    res_next.nmax = d_pos ? hi_s : s_lo;
    den_s = $signed({1'b0, res_next.den});

    res_next.active = axis_on && !d_zero;
    if (!axis_on) begin
      res_next.ok = 1'b1;
    end else if (d_zero) begin
      res_next.ok = !miss;
    end else begin
      res_next.ok = (res_next.nmin <= res_next.nmax) && (res_next.nmin <= den_s)
                    && !res_next.nmax[DiffWidth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

@@ src/sbst_merge.sv @@
`default_nettype none

module sbst_merge import sbst_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en_prod,
  input  wire logic  en_out,
  input  wire lane_t lanes [NumAxes],
  output logic       hit
);

  logic signed [ProdWidth-1:0] lhs      [NumPairs];
  logic signed [ProdWidth-1:0] rhs      [NumPairs];
  logic signed [ProdWidth-1:0] lhs_next [NumPairs];
  logic signed [ProdWidth-1:0] rhs_next [NumPairs];
  logic [NumPairs-1:0]         pair_on;
  logic [NumPairs-1:0]         pair_on_next;
  logic                        all_ok;
  logic                        hit_next;

  // Entry of axis i must not come after exit of axis j:
  // nmin_i / den_i <= nmax_j / den_j, with both denominators positive.
  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    localparam int unsigned I = PairEntry[p];
    localparam int unsigned J = PairExit[p];
    assign lhs_next[p] = lanes[I].nmin * $signed({1'b0, lanes[J].den});
    assign rhs_next[p] = lanes[J].nmax * $signed({1'b0, lanes[I].den});
    assign pair_on_next[p] = lanes[I].active && lanes[J].active;
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      lhs     <= lhs_next;
      rhs     <= rhs_next;
      pair_on <= pair_on_next;
      all_ok  <= lanes[AxisX].ok && lanes[AxisY].ok && lanes[AxisZ].ok;
    end
  end

  always_comb begin
    hit_next = all_ok;
    for (int p = 0; p < NumPairs; p++) begin
      if (pair_on[p] && (lhs[p] > rhs[p])) begin
        hit_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      hit <= hit_next;
    end
  end

endmodule

`default_nettype wire

@@ src/segment_box_slab_test.sv @@
`default_nettype none

// Segment versus axis-aligned box test, slab method, exact integer arithmetic.
// The req channel carries one segment (start, end) and one box (lo, hi) per
// transfer; the rsp channel returns one hit bit per request, in order. The
// cfg channel writes dimension_count; it is always ready, and a value of two
// ignores the z fields while any other value tests all three axes.
// Throughput is one request per cycle until a stalled receiver lets the pipeline fill.
// The result of a request transferred on req is registered in the lane, product
// and output stages in turn and can then be transferred on rsp.
// The three axis lanes form the first stage, the cross products of the merge
// unit the second, and the final compare loads the output register.
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it loads, so bubbles close up and requests keep being taken
// while a result waits, until all three stages are full. When the receiver
// stalls, the result holds on rsp and req.ready falls once the pipeline fills.
// Reset (synchronous, active high) empties the pipeline and sets
// dimension_count to three.

module segment_box_slab_test import sbst_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  sbst_cfg_if.sink    cfg,
  sbst_req_if.sink    req,
  sbst_rsp_if.source  rsp
);

  logic [DimWidth-1:0] dimension_count;

  // Stage valid bits: lanes, products, output register.
  logic v1;
  logic v2;
  logic v3;
  logic en1;
  logic en2;
  logic en3;

  logic                         axis_on [NumAxes];
  logic signed [CoordWidth-1:0] s_in    [NumAxes];
  logic signed [CoordWidth-1:0] e_in    [NumAxes];
  logic signed [CoordWidth-1:0] lo_in   [NumAxes];
  logic signed [CoordWidth-1:0] hi_in   [NumAxes];
  lane_t                        lane_res [NumAxes];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension_count <= DimCountReset;
    end else if (cfg.valid && cfg.ready) begin
      dimension_count <= cfg.data;
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign req.ready = en1;
  assign rsp.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= req.valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  assign axis_on[AxisX] = 1'b1;
  assign axis_on[AxisY] = 1'b1;
  assign axis_on[AxisZ] = (dimension_count != DimTwo);

  assign s_in[AxisX]  = req.start_x;
  assign s_in[AxisY]  = req.start_y;
  assign s_in[AxisZ]  = req.start_z;
  assign e_in[AxisX]  = req.end_x;
  assign e_in[AxisY]  = req.end_y;
  assign e_in[AxisZ]  = req.end_z;
  assign lo_in[AxisX] = req.box_lo_x;
  assign lo_in[AxisY] = req.box_lo_y;
  assign lo_in[AxisZ] = req.box_lo_z;
  assign hi_in[AxisX] = req.box_hi_x;
  assign hi_in[AxisY] = req.box_hi_y;
  assign hi_in[AxisZ] = req.box_hi_z;

  // One lane per axis reduces its two slabs to an entry and an exit bound
  // over a common denominator and checks them against each other and [0, 1].
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    sbst_lane u_lane (
      .clk     (clk),
      .en      (en1),
      .axis_on (axis_on[a]),
      .s       (s_in[a]),
      .e       (e_in[a]),
      .lo      (lo_in[a]),
      .hi      (hi_in[a]),
      .res     (lane_res[a])
    );
  end

  // The merge unit checks every entry bound against every other axis's exit
  // bound by cross multiplication and drives the output register.
  sbst_merge u_merge (
    .clk     (clk),
    .en_prod (en2),
    .en_out  (en3),
    .lanes   (lane_res),
    .hit     (rsp.hit)
  );

  // A transfer on req always lands in the lane stage.
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v1)
    else $error("accepted request did not enter the lane stage");

  // Back pressure reaches req only when every stage holds a request.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> v1 && v2 && v3)
    else $error("request refused while the pipeline had room");

  // A stalled output keeps the product stage occupied.
  a_prod_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && v3 && !rsp.ready |=> v2)
    else $error("product stage lost a request during a stall");

endmodule

`default_nettype wire

@@ tb/segment_box_slab_test_tb.sv @@
`timescale 1ns / 1ps

module segment_box_slab_test_tb;
  import sbst_pkg::*;

  // Extremes of one signed coordinate.
  localparam int CoordMin = -(1 <<< (CoordWidth - 1));
  localparam int CoordMax = (1 <<< (CoordWidth - 1)) - 1;

  // One test as the testbench holds it: the segment's two end points and the
  // box corners, each indexed by axis (index 0 is x).
  typedef struct packed {
    logic [NumAxes-1:0][CoordWidth-1:0] start_pt;
    logic [NumAxes-1:0][CoordWidth-1:0] stop_pt;
    logic [NumAxes-1:0][CoordWidth-1:0] lo;
    logic [NumAxes-1:0][CoordWidth-1:0] hi;
  } segment_box_t;

  logic clk;
  logic rst = 1'b1;

  // Everything the testbench drives starts at a known value at time zero.
  logic                cfg_valid = 1'b0;
  logic [DimWidth-1:0] cfg_data = DimCountReset;
  logic                req_valid = 1'b0;
  segment_box_t        req_item = '0;
  logic                rsp_ready = 1'b0;

  sbst_cfg_if cfg_bus ();
  sbst_req_if req_bus ();
  sbst_rsp_if rsp_bus ();

  assign cfg_bus.valid    = cfg_valid;
  assign cfg_bus.data     = cfg_data;
  assign req_bus.valid    = req_valid;
  assign req_bus.start_x  = req_item.start_pt[AxisX];
  assign req_bus.start_y  = req_item.start_pt[AxisY];
  assign req_bus.start_z  = req_item.start_pt[AxisZ];
  assign req_bus.end_x    = req_item.stop_pt[AxisX];
  assign req_bus.end_y    = req_item.stop_pt[AxisY];
  assign req_bus.end_z    = req_item.stop_pt[AxisZ];
  assign req_bus.box_lo_x = req_item.lo[AxisX];
  assign req_bus.box_lo_y = req_item.lo[AxisY];
  assign req_bus.box_lo_z = req_item.lo[AxisZ];
  assign req_bus.box_hi_x = req_item.hi[AxisX];
  assign req_bus.box_hi_y = req_item.hi[AxisY];
  assign req_bus.box_hi_z = req_item.hi[AxisZ];
  assign rsp_bus.ready    = rsp_ready;

  segment_box_slab_test uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Tests waiting to be offered, hit bits waiting to come back, and the
  // dimension setting that the block currently holds.
  segment_box_t        pending_tests[$];
  bit                  expected_hits[$];
  logic [DimWidth-1:0] dim_setting = DimCountReset;

  int  error_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  gaps_on = 1'b1;
  bit  rx_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends a test at the back of the pending list.
  function automatic void add_test(input segment_box_t t);
    pending_tests.insert(pending_tests.size(), t);
  endfunction

  // Exact slab test. Every bound is kept as a fraction num/den with a
  // positive denominator, and bounds are ordered by cross multiplication, so
  // no rounding can hide a grazing contact. Operands fit in 17 bits, which
  // leaves the 64-bit products far from overflow.
  function automatic bit slab_hit(input segment_box_t t, input logic [DimWidth-1:0] dims);
    int     axes;
    bit     has_min, has_max, miss, hit;
    longint s, e, lo, hi, d, slope, reach, cn, cd;
    longint min_n, min_d, max_n, max_d;
    axes = (dims == DimTwo) ? 2 : 3;
    has_min = 1'b0;
    has_max = 1'b0;
    miss = 1'b0;
    min_n = 0;
    min_d = 1;
    max_n = 0;
    max_d = 1;
    for (int a = 0; a < axes; a++) begin
      s = $signed(t.start_pt[a]);
      e = $signed(t.stop_pt[a]);
      lo = $signed(t.lo[a]);
      hi = $signed(t.hi[a]);
      d = e - s;
      // First the upper face of this axis, then the lower face.
      for (int k = 0; k < 2; k++) begin
        slope = (k == 0) ? d : -d;
        reach = (k == 0) ? (hi - s) : (s - lo);
        if (slope < 0) begin
          cn = -reach;
          cd = -slope;
          if (!has_min || cn * min_d > min_n * cd) begin
            min_n = cn;
            min_d = cd;
            has_min = 1'b1;
          end
        end else if (slope > 0) begin
          cn = reach;
          cd = slope;
          if (!has_max || cn * max_d < max_n * cd) begin
            max_n = cn;
            max_d = cd;
            has_max = 1'b1;
          end
        end else if (reach < 0) begin
          // Parallel to this face and on its outer side.
          miss = 1'b1;
        end
      end
    end
    hit = !miss;
    if (hit && has_min && has_max && min_n * max_d > max_n * min_d) hit = 1'b0;
    if (hit && has_min && min_n > min_d) hit = 1'b0;
    if (hit && has_max && max_n < 0) hit = 1'b0;
    return hit;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one. With gaps
  // switched off a phase runs back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [CoordWidth-1:0] clamp_coord(input int v);
    if (v < CoordMin) v = CoordMin;
    else if (v > CoordMax) v = CoordMax;
    return v[CoordWidth-1:0];
  endfunction

  function automatic int near(input int c, input int w);
    return c + int'($urandom_range(0, 2 * w)) - w;
  endfunction

  // A coordinate on a face of the box or just outside it.
  function automatic int face_coord(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      default: return hi + 1;
    endcase
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0: return CoordMin;
      1: return CoordMin + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return CoordMax - 1;
      default: return CoordMax;
    endcase
  endfunction

  // Random test. Most are built around a box so that hits and misses both
  // come often; the rest are edge contacts, extreme values and plain noise.
  function automatic segment_box_t rand_test();
    segment_box_t          t;
    int                    kind, w, c, lo, hi, s, e, tmp;
    logic [CoordWidth-1:0] raw;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: w = $urandom_range(1, 16);
      1: w = $urandom_range(1, 600);
      default: w = $urandom_range(1, 12000);
    endcase
    for (int a = 0; a < NumAxes; a++) begin
      c = int'($urandom_range(0, 60000)) - 30000;
      lo = c - int'($urandom_range(0, w));
      hi = c + int'($urandom_range(0, w));
      s = near(c, 3 * w);
      e = near(c, 3 * w);
      if (kind < 40) begin
        // Segment scattered around the box.
      end else if (kind < 55) begin
        s = lo + int'($urandom_range(0, hi - lo));
      end else if (kind < 65) begin
        if ($urandom_range(0, 3) == 0) s = face_coord(lo, hi);
        if ($urandom_range(0, 1) == 1) e = s;
      end else if (kind < 75) begin
        s = face_coord(lo, hi);
        e = face_coord(lo, hi);
      end else if (kind < 85) begin
        s = extreme_coord();
        e = extreme_coord();
        lo = extreme_coord();
        hi = extreme_coord();
      end else begin
        raw = CoordWidth'($urandom);
        s = $signed(raw);
        raw = CoordWidth'($urandom);
        e = $signed(raw);
        raw = CoordWidth'($urandom);
        lo = $signed(raw);
        raw = CoordWidth'($urandom);
        hi = $signed(raw);
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
      // Now and then an inverted box on one axis.
      if (kind < 75 && $urandom_range(0, 19) == 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
      t.start_pt[a] = clamp_coord(s);
      t.stop_pt[a] = clamp_coord(e);
      t.lo[a] = clamp_coord(lo);
      t.hi[a] = clamp_coord(hi);
    end
    return t;
  endfunction

  function automatic segment_box_t seg_box(input int sx, input int sy, input int sz,
                                           input int ex, input int ey, input int ez,
                                           input int lx, input int ly, input int lz,
                                           input int hx, input int hy, input int hz);
    segment_box_t t;
    t.start_pt = {clamp_coord(sz), clamp_coord(sy), clamp_coord(sx)};
    t.stop_pt = {clamp_coord(ez), clamp_coord(ey), clamp_coord(ex)};
    t.lo = {clamp_coord(lz), clamp_coord(ly), clamp_coord(lx)};
    t.hi = {clamp_coord(hz), clamp_coord(hy), clamp_coord(hx)};
    return t;
  endfunction

  // Hand-picked cases: extreme coordinates, degenerate segments, grazing
  // contacts on faces, edges and corners, and inverted boxes. Several differ
  // only in z, so they answer differently in the two-axis setting.
  task automatic queue_directed();
    // A point segment sitting on a point box.
    add_test(seg_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // The full diagonal against the whole space, then through the origin.
    add_test(seg_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                     CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    add_test(seg_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                     0, 0, 0, 0, 0, 0));
    // The diagonal passes x = 0 and y = 1 at different times.
    add_test(seg_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                     0, 1, 0, 0, 1, 0));
    // Reversed diagonal that touches the top corner only at its start.
    add_test(seg_box(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin,
                     CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    // Degenerate segments: outside, then on a face.
    add_test(seg_box(5, 5, 5, 5, 5, 5, 0, 0, 0, 4, 4, 4));
    add_test(seg_box(4, 2, 2, 4, 2, 2, 0, 0, 0, 4, 4, 4));
    // Parallel to x, sliding along the lower y face, then one unit below it.
    add_test(seg_box(-10, 0, 0, 10, 0, 0, -1, 0, -1, 1, 5, 1));
    add_test(seg_box(-10, -1, 0, 10, -1, 0, -1, 0, -1, 1, 5, 1));
    // Ends exactly on a face, then one short of it.
    add_test(seg_box(-10, 0, 0, -1, 0, 0, -1, -1, -1, 5, 1, 1));
    add_test(seg_box(-10, 0, 0, -2, 0, 0, -1, -1, -1, 5, 1, 1));
    // Starts on a face and leaves.
    add_test(seg_box(5, 0, 0, 20, 0, 0, -1, -1, -1, 5, 1, 1));
    // Diagonal that grazes a box corner, then misses the next box by one.
    add_test(seg_box(0, 10, 0, 10, 0, 0, 5, 5, 0, 10, 10, 0));
    add_test(seg_box(0, 10, 0, 10, 0, 0, 6, 6, 0, 10, 10, 0));
    // Inverted box on x, then on z only.
    add_test(seg_box(-10, 0, 0, 10, 0, 0, 5, -1, -1, -5, 1, 1));
    add_test(seg_box(-10, -10, 0, 10, 10, 0, -1, -1, 3, 1, 1, -3));
    // Overlap in x and y but not in z.
    add_test(seg_box(-10, -10, 0, 10, 10, 0, -1, -1, 1, 1, 1, 4));
    // A point box lying on the segment's interior.
    add_test(seg_box(-6, -3, 9, 6, 3, -3, 2, 1, 1, 2, 1, 1));
    // Enters along x only after it has left along y.
    add_test(seg_box(0, 0, 0, 10, 20, 0, 6, 0, 0, 10, 10, 0));
    // Extreme span crossing a full-width box, then a box inverted everywhere.
    add_test(seg_box(CoordMax, 0, 0, CoordMin, 0, 0,
                     CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax));
    add_test(seg_box(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax,
                     CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin));
  endtask

  task automatic queue_random(input int count);
    repeat (count) add_test(rand_test());
  endtask

  // Returns at a clock edge once every queued test has been transferred and
  // every hit bit has come back, so the block holds nothing.
  task automatic wait_drained();
    while (pending_tests.size() != 0 || expected_hits.size() != 0) @(posedge clk);
  endtask

  // The configuration channel is written only while the block is empty.
  task automatic write_dims(input logic [DimWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    dim_setting = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Request driver. An accepted transfer turns into an expected hit bit at
  // the setting in force; the next test is offered after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_hits.insert(expected_hits.size(),
                             slab_hit(pending_tests.pop_front(), dim_setting));
        accepted_count++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap > 0) begin
          req_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_tests.size() != 0) begin
          req_valid <= 1'b1;
          req_item <= pending_tests[0];
          send_gap <= pick_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each transfer on the response channel is matched against
  // the oldest expected hit bit; ready drops at random and during the hold.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else if (rsp_bus.hit !== expected_hits[0]) begin
          report_mismatch($sformatf("result %0d: hit %b, expected %b",
                                    result_count, rsp_bus.hit, expected_hits[0]));
          void'(expected_hits.pop_front());
        end else begin
          void'(expected_hits.pop_front());
        end
        result_count++;
      end
      if (rx_hold) begin
        rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        rsp_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        rsp_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // Long receiver hold-off early in the run. The sender keeps offering tests
  // all the while, so the pipeline fills and the request channel must stall.
  initial begin
    while (accepted_count < 150) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Main sequence: reset, then phases at different dimension settings. The
  // setting is changed only after the block has drained.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting, three axes.
    queue_directed();
    queue_random(250);
    wait_drained();

    // Two axes: the z fields must have no effect.
    write_dims(DimTwo);
    queue_directed();
    queue_random(300);
    wait_drained();
    // The sender has paused until everything came back; now a stretch with
    // no idling on either side.
    gaps_on = 1'b0;
    queue_random(200);
    wait_drained();
    gaps_on = 1'b1;

    // Values other than two all select three axes.
    write_dims(2'd0);
    queue_random(150);
    wait_drained();
    write_dims(2'd1);
    queue_random(150);
    wait_drained();
    write_dims(DimCountReset);
    queue_random(300);
    wait_drained();
    write_dims(DimTwo);
    queue_random(150);
    wait_drained();

    // Let a stray late result show up before the verdict.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // A hung handshake ends here.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected", expected_hits.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbst_pkg.sv
src/sbst_if.sv
src/sbst_lane.sv
src/sbst_merge.sv
src/segment_box_slab_test.sv
tb/segment_box_slab_test_tb.sv
